// File: rtl/sidechain_ducking_compressor_unit_macros.svh
// Assertion helpers used by the controller
`ifndef SIDECHAIN_DUCKING_COMPRESSOR_UNIT_MACROS_SVH
`define SIDECHAIN_DUCKING_COMPRESSOR_UNIT_MACROS_SVH

// same-cycle implication
`define SDC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdc: check failed");

// next-cycle implication
`define SDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sdc: sequence check failed");

`endif

// File: rtl/sdc_pkg.sv
package sdc_pkg;

	// sequencer step codes, shared by controller and datapath
	localparam logic [3:0] OP_IDLE = 4'd0;
	localparam logic [3:0] OP_E1   = 4'd1;
	localparam logic [3:0] OP_E2   = 4'd2;
	localparam logic [3:0] OP_E3   = 4'd3;
	localparam logic [3:0] OP_NRM  = 4'd4;
	localparam logic [3:0] OP_L1   = 4'd5;
	localparam logic [3:0] OP_L2   = 4'd6;
	localparam logic [3:0] OP_G1   = 4'd7;
	localparam logic [3:0] OP_G2   = 4'd8;
	localparam logic [3:0] OP_G3   = 4'd9;
	localparam logic [3:0] OP_F1   = 4'd10;
	localparam logic [3:0] OP_F2   = 4'd11;
	localparam logic [3:0] OP_OUT  = 4'd12;

	// register indexes
	localparam logic [2:0] REG_ATTACK  = 3'd0;
	localparam logic [2:0] REG_RELEASE = 3'd1;
	localparam logic [2:0] REG_THRESH  = 3'd2;
	localparam logic [2:0] REG_SLOPE   = 3'd3;
	localparam logic [2:0] REG_MIX     = 3'd4;

	localparam logic [15:0] DB_FLOOR       = 16'd30720;
	localparam logic [19:0] DB_PER_OCT_Q16 = 20'd394568;
	localparam logic [19:0] OCT_PER_DB_Q16 = 20'd10885;
	localparam logic [16:0] UNITY          = 17'd65536;
	localparam int          TAB_MAX        = 1024;

	typedef logic [16:0] tab_t [0:TAB_MAX-1];

	typedef struct packed {
		logic [3:0] op;
		logic       load;
	} sdc_cmd_t;

	typedef struct packed {
		logic zero;
		logic top;
		logic out_busy;
	} sdc_stat_t;

	typedef struct packed {
		logic [15:0]        attack;
		logic [15:0]        rel;
		logic signed [15:0] thresh;
		logic [15:0]        slope;
		logic [16:0]        mix;
	} sdc_cfg_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v0);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bt;
		v = v0;
		res = 64'd0;
		bt = 64'd1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 64'd0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// log2(1+i/2^tb) in Q16 by repeated squaring
	function automatic tab_t build_log(input int tb);
		tab_t        t;
		logic [63:0] x;
		logic [63:0] bits_v;
		for (int i = 0; i < TAB_MAX; i++) begin
			t[i] = 17'd0;
			if (i < (1 << tb)) begin
				x = (64'd1 << 30) + (64'(i) << (30 - tb));
				bits_v = 64'd0;
				for (int k = 0; k < 17; k++) begin
					x = (x * x + (64'd1 << 29)) >> 30;
					bits_v = bits_v << 1;
					if (x >= (64'd2 << 30)) begin
						bits_v = bits_v | 64'd1;
						x = x >> 1;
					end
				end
				t[i] = 17'((bits_v + 64'd1) >> 1);
			end
		end
		return t;
	endfunction

	// 2^(-i/2^tb) in Q16 from products of roots of one half
	function automatic tab_t build_exp(input int tb);
		tab_t        t;
		logic [63:0] roots [0:9];
		logic [63:0] r;
		logic [63:0] acc;
		r = isqrt64(64'd1 << 59);
		for (int k = 0; k < 10; k++) begin
			roots[k] = r;
			r = isqrt64(r << 30);
		end
		for (int i = 0; i < TAB_MAX; i++) begin
			t[i] = 17'd0;
			if (i < (1 << tb)) begin
				acc = 64'd1 << 30;
				for (int k = 0; k < tb; k++)
					if (((i >> k) & 1) != 0)
						acc = (acc * roots[tb - 1 - k] + (64'd1 << 29)) >> 30;
				t[i] = 17'((acc + (64'd1 << 13)) >> 14);
			end
		end
		return t;
	endfunction

endpackage

// File: rtl/sdc_ctrl.sv
module sdc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sdc_pkg::sdc_stat_t st,
	output sdc_pkg::sdc_cmd_t  cmd
);
	import sdc_pkg::*;
	`include "sidechain_ducking_compressor_unit_macros.svh"

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == OP_IDLE);
	assign cmd.op   = state_q;
	assign cmd.load = in_valid && in_ready;

	// step sequencing
	always_comb begin
		state_d = state_q;
		case (state_q)
			OP_IDLE: if (in_valid) state_d = OP_E1;
			OP_E1:   state_d = OP_E2;
			OP_E2:   state_d = OP_E3;
			OP_E3:   state_d = OP_NRM;
			OP_NRM: begin
				if (st.zero) state_d = OP_G1;
				else if (st.top) state_d = OP_L1;
			end
			OP_L1:   state_d = OP_L2;
			OP_L2:   state_d = OP_G1;
			OP_G1:   state_d = OP_G2;
			OP_G2:   state_d = OP_G3;
			OP_G3:   state_d = OP_F1;
			OP_F1:   state_d = OP_F2;
			OP_F2:   state_d = OP_OUT;
			OP_OUT:  if (!st.out_busy) state_d = OP_IDLE;
			default: state_d = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= OP_IDLE;
		else state_q <= state_d;
	end

	`SDC_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_q == OP_E1)
	`SDC_ASSERT_NEXT(a_out_done, (state_q == OP_OUT) && !st.out_busy, state_q == OP_IDLE)
	`SDC_ASSERT_NOW(a_zero_not_top, (state_q == OP_NRM) && st.zero, !st.top)
endmodule

// File: rtl/sdc_datapath.sv
module sdc_datapath #(
	parameter int SB  = 24,
	parameter int EFB = 8,
	parameter int TB  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sdc_pkg::sdc_cmd_t     cmd,
	output sdc_pkg::sdc_stat_t    st,
	input  sdc_pkg::sdc_cfg_t     cfg,
	input  logic signed [SB-1:0]  main_sample,
	input  logic signed [SB-1:0]  side_sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [SB-1:0]  out_sample
);
	import sdc_pkg::*;

	localparam int W   = SB - 1 + EFB;
	localparam int AW0 = (W > SB) ? W : SB;
	localparam int AW  = (AW0 > 22) ? AW0 : 22;
	localparam int PW  = AW + 20;
	localparam tab_t LOG_TAB = build_log(TB);
	localparam tab_t EXP_TAB = build_exp(TB);
	localparam logic [SB-2:0] SMAX_U = {(SB-1){1'b1}};
	localparam logic signed [SB+1:0] SMAX = $signed({3'b000, SMAX_U});
	localparam logic signed [SB+1:0] SMIN = -SMAX - 1;

	logic signed [SB-1:0] main_q;
	logic [W-1:0]         x_q;
	logic [15:0]          c_q;
	logic [W-1:0]         env_q;
	logic [W-1:0]         norm_q;
	logic [5:0]           k_q;
	logic [PW-1:0]        acc_q;
	logic [PW-1:0]        prod_q;
	logic signed [15:0]   level_q;
	logic                 gt_q;
	logic [16:0]          gain_q;
	logic                 out_valid_q;
	logic signed [SB-1:0] out_q;

	logic [AW-1:0] mul_a;
	logic [19:0]   mul_b;

	// key magnitude, saturated
	logic [SB-1:0] side_neg;
	logic [SB-2:0] mag;
	logic [W-1:0]  x_in;
	assign side_neg = ~side_sample + 1'b1;
	always_comb begin
		if (!side_sample[SB-1]) mag = side_sample[SB-2:0];
		else if (side_neg[SB-1]) mag = SMAX_U;
		else mag = side_neg[SB-2:0];
	end
	assign x_in = W'(mag) << EFB;

	// envelope update
	logic [PW:0]   env_sum;
	logic [W-1:0]  env_new;
	assign env_sum = {1'b0, acc_q} + {1'b0, prod_q} + (PW+1)'(32768);
	assign env_new = env_sum[W+15:16];

	// level from normalised envelope
	logic [TB-1:0] idx;
	logic [21:0]   neg;
	logic [PW:0]   down_sum;
	logic [PW:0]   down_w;
	logic [15:0]   down;
	assign idx      = norm_q[W-2 -: TB];
	assign neg      = {10'd0, k_q + 6'd1, 6'd0} * 22'd1024 - 22'(LOG_TAB[idx]);
	assign down_sum = {1'b0, prod_q} + (PW+1)'(1 << 23);
	assign down_w   = down_sum >> 24;
	assign down     = (down_w > (PW+1)'(DB_FLOOR)) ? DB_FLOOR : down_w[15:0];

	// reduction and gain
	logic signed [16:0] over;
	logic [PW:0]        red_sum;
	logic [16:0]        red;
	logic [PW:0]        oct;
	logic [PW:0]        sh;
	logic [16:0]        gexp;
	logic [16:0]        gain_new;
	assign over     = {level_q[15], level_q} - {cfg.thresh[15], cfg.thresh};
	assign red_sum  = {1'b0, prod_q} + (PW+1)'(32768);
	assign red      = red_sum[32:16];
	assign oct      = ({1'b0, prod_q} + (PW+1)'(128)) >> 8;
	assign sh       = oct >> 16;
	assign gexp     = EXP_TAB[oct[15 -: TB]];
	assign gain_new = !gt_q ? UNITY :
		((sh >= (PW+1)'(32)) ? 17'd0 : (gexp >> sh[4:0]));

	// blend factor and output scaling
	logic [16:0]          mix_m;
	logic [16:0]          f;
	logic [SB-1:0]        amag;
	logic [PW:0]          r_sum;
	logic [SB:0]          r;
	logic signed [SB+1:0] rs;
	logic signed [SB-1:0] res;
	assign mix_m = (cfg.mix > UNITY) ? UNITY : cfg.mix;
	assign f     = UNITY - red_sum[32:16];
	assign amag  = main_q[SB-1] ? (~main_q + 1'b1) : main_q;
	assign r_sum = {1'b0, prod_q} + (PW+1)'(32768);
	assign r     = r_sum[SB+16:16];
	assign rs    = main_q[SB-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
	always_comb begin
		if (rs > SMAX) res = SMAX[SB-1:0];
		else if (rs < SMIN) res = SMIN[SB-1:0];
		else res = rs[SB-1:0];
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_E1: begin mul_a = AW'(env_q); mul_b = 20'(c_q); end
			OP_E2: begin mul_a = AW'(x_q); mul_b = 20'(UNITY - {1'b0, c_q}); end
			OP_L1: begin mul_a = AW'(neg); mul_b = DB_PER_OCT_Q16; end
			OP_G1: begin mul_a = AW'(over[16:0]); mul_b = 20'(cfg.slope); end
			OP_G2: begin mul_a = AW'(red); mul_b = OCT_PER_DB_Q16; end
			OP_F1: begin mul_a = AW'(mix_m); mul_b = 20'(UNITY - gain_q); end
			OP_F2: begin mul_a = AW'(amag); mul_b = 20'(f); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// datapath registers; the final product holds while the result waits
	always_ff @(posedge clk) begin
		if (cmd.op != OP_OUT) prod_q <= mul_a * mul_b;
		case (cmd.op)
			OP_IDLE: begin
				if (cmd.load) begin
					main_q <= main_sample;
					x_q    <= x_in;
					c_q    <= (x_in > env_q) ? cfg.attack : cfg.rel;
				end
			end
			OP_E2: acc_q <= prod_q;
			OP_E3: begin
				norm_q <= env_new;
				k_q    <= 6'd0;
			end
			OP_NRM: begin
				if (norm_q == '0) level_q <= -$signed(DB_FLOOR);
				else if (!norm_q[W-1]) begin
					norm_q <= norm_q << 1;
					k_q    <= k_q + 6'd1;
				end
			end
			OP_L2: level_q <= -$signed(down);
			OP_G1: gt_q <= (level_q > cfg.thresh);
			OP_G3: gain_q <= gain_new;
			default: ;
		endcase
		if ((cmd.op == OP_OUT) && !st.out_busy) out_q <= res;
	end

	// envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) env_q <= '0;
		else if (cmd.op == OP_E3) env_q <= env_new;
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if ((cmd.op == OP_OUT) && !st.out_busy) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign st.zero     = (norm_q == '0);
	assign st.top      = norm_q[W-1];
	assign st.out_busy = out_valid_q && !out_ready;
	assign out_valid   = out_valid_q;
	assign out_sample  = out_q;
endmodule

// File: rtl/sidechain_ducking_compressor_unit.sv
// Sidechain ducking compressor. Each input word carries a main sample and a key
// sample; one ducked main sample comes out per word. Processing is sequential
// through one shared multiplier: ten fixed steps, two log steps that are skipped
// when the envelope is zero, and a one-bit-per-cycle normalising shift of the
// envelope (W = SAMPLE_BITS-1+ENV_FRAC_BITS, 31 by default). The next word is
// taken once the result of the last one is loaded into the output register,
// which may first have to wait for that register to empty.
// Registers sit on an APB port at byte addresses 0,4,8,12,16: attack, release,
// threshold (Q8.8 dB), slope, mix.
module sidechain_ducking_compressor_unit #(
	parameter int SAMPLE_BITS   = 24,
	parameter int ENV_FRAC_BITS = 8,
	parameter int TABLE_BITS    = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] main_sample,
	input  logic signed [SAMPLE_BITS-1:0] side_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [4:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import sdc_pkg::*;

	sdc_cfg_t  cfg_q;
	sdc_cmd_t  cmd;
	sdc_stat_t st;
	logic      wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack <= 16'd65400;
			cfg_q.rel    <= 16'd65509;
			cfg_q.thresh <= -16'sd7680;
			cfg_q.slope  <= 16'd49152;
			cfg_q.mix    <= 17'd65536;
		end else if (wr) begin
			case (paddr[4:2])
				REG_ATTACK:  cfg_q.attack <= pwdata[15:0];
				REG_RELEASE: cfg_q.rel    <= pwdata[15:0];
				REG_THRESH:  cfg_q.thresh <= $signed(pwdata[15:0]);
				REG_SLOPE:   cfg_q.slope  <= pwdata[15:0];
				REG_MIX:     cfg_q.mix    <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr[4:2])
			REG_ATTACK:  prdata = {16'd0, cfg_q.attack};
			REG_RELEASE: prdata = {16'd0, cfg_q.rel};
			REG_THRESH:  prdata = {16'd0, cfg_q.thresh};
			REG_SLOPE:   prdata = {16'd0, cfg_q.slope};
			REG_MIX:     prdata = {15'd0, cfg_q.mix};
			default:     prdata = 32'd0;
		endcase
	end

	sdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	sdc_datapath #(
		.SB  (SAMPLE_BITS),
		.EFB (ENV_FRAC_BITS),
		.TB  (TABLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg         (cfg_q),
		.main_sample (main_sample),
		.side_sample (side_sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_sample  (out_sample)
	);
endmodule

// File: test/tb_sidechain_ducking_compressor_unit.sv
`timescale 1ns / 1ps

module tb_sidechain_ducking_compressor_unit;
	import sdc_pkg::*;

	localparam int  SW       = 24;
	localparam int  EFB      = 8;
	localparam int  TB       = 8;
	localparam int  TSZ      = 1 << TB;
	localparam int  FSB      = SW - 1 + EFB;
	localparam int  SETTLE   = 64;
	localparam int  NPHASE   = 9;
	localparam longint SMAX  = (64'sd1 << (SW - 1)) - 1;

	typedef struct {
		logic signed [SW-1:0] main_s;
		logic signed [SW-1:0] side_s;
	} word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic signed [SW-1:0] main_sample = '0;
	logic signed [SW-1:0] side_sample = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [SW-1:0] out_sample;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [4:0]           paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;

	sidechain_ducking_compressor_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.main_sample(main_sample), .side_sample(side_sample),
		.out_valid(out_valid), .out_ready(out_ready), .out_sample(out_sample),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state: settings and envelope
	longint   att_c, rel_c, slope_c, mix_c, thr_c, env_acc;
	longint   log2_q16 [TSZ];
	longint   pow2_q16 [TSZ];

	word_t    word_q [$];
	logic signed [SW-1:0] ducked_q [$];
	int       fails = 0;
	int       n_in = 0, n_out = 0, n_reduced = 0, n_push = 0;
	bit       quiet = 1'b0;
	bit       hold_req = 1'b0;
	bit       hold_on = 1'b0;
	int       gap = 0, stall = 0;

	initial forever #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic longint int_sqrt(input longint unsigned v0);
		longint unsigned v, res, b;
		v = v0; res = 0; b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else
				res = res >> 1;
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	// log2 and exp2 lookup tables in Q16
	task automatic make_tables();
		longint unsigned rt [TB];
		longint unsigned r, x, acc, bv;
		r = int_sqrt(64'd1 << 59);
		for (int k = 0; k < TB; k++) begin
			rt[k] = r;
			r = int_sqrt(r << 30);
		end
		for (int i = 0; i < TSZ; i++) begin
			x = (64'd1 << 30) + (longint'(i) << (30 - TB));
			bv = 0;
			for (int k = 0; k < 17; k++) begin
				x = (x * x + (64'd1 << 29)) >> 30;
				bv = bv << 1;
				if (x >= (64'd2 << 30)) begin
					bv = bv | 1;
					x = x >> 1;
				end
			end
			log2_q16[i] = (bv + 1) >> 1;
			acc = 64'd1 << 30;
			for (int k = 0; k < TB; k++)
				if ((i >> k) & 1)
					acc = (acc * rt[TB - 1 - k] + (64'd1 << 29)) >> 30;
			pow2_q16[i] = (acc + (64'd1 << 13)) >> 14;
		end
	endtask

	// envelope update, level, gain and blend for one word
	function automatic logic signed [SW-1:0] duck(input word_t w);
		longint mag, x, c, lvl, neg, down, over, red, oct, sh, gain, m, f, amag, r, res;
		longint mn, idx;
		int     p;
		mn = w.main_s;
		mag = w.side_s;
		if (mag < 0) mag = -mag;
		if (mag > SMAX) mag = SMAX;
		x = mag << EFB;
		c = (x > env_acc) ? att_c : rel_c;
		env_acc = (c * env_acc + (65536 - c) * x + 32768) >>> 16;
		if (env_acc == 0)
			lvl = -30720;
		else begin
			p = 0;
			while (p < 63 && (env_acc >>> (p + 1)) != 0) p++;
			idx = (p >= TB) ? (env_acc >>> (p - TB)) : (env_acc << (TB - p));
			idx = idx & (TSZ - 1);
			neg = longint'(FSB - p) * 65536 - log2_q16[idx];
			down = (neg * 394568 + (64'sd1 << 23)) >>> 24;
			if (down > 30720) down = 30720;
			lvl = -down;
		end
		gain = 65536;
		if (lvl > thr_c) begin
			over = lvl - thr_c;
			red = (over * slope_c + 32768) >>> 16;
			oct = (red * 10885 + 128) >>> 8;
			sh = oct >>> 16;
			gain = (sh >= 32) ? 0 : (pow2_q16[(oct & 16'hFFFF) >> (16 - TB)] >>> sh);
			n_reduced++;
		end
		m = (mix_c > 65536) ? 65536 : mix_c;
		f = 65536 - ((m * (65536 - gain) + 32768) >>> 16);
		amag = (mn < 0) ? -mn : mn;
		r = (amag * f + 32768) >>> 16;
		res = (mn < 0) ? -r : r;
		if (res > SMAX) res = SMAX;
		if (res < -SMAX - 1) res = -SMAX - 1;
		return res[SW-1:0];
	endfunction

	// sender: feeds queued words with random gaps
	always @(posedge clk) begin
		word_t w;
		bit    busy;
		if (arst_n) begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				w.main_s = main_sample;
				w.side_s = side_sample;
				ducked_q.push_back(duck(w));
				n_in++;
				busy = 1'b0;
				if (!quiet && $urandom_range(0, 3) == 0)
					gap = $urandom_range(1, 14);
			end
			if (!busy) begin
				if (gap > 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (word_q.size() != 0) begin
					w = word_q.pop_front();
					in_valid <= 1'b1;
					main_sample <= w.main_s;
					side_sample <= w.side_s;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_req && !hold_on) begin
			hold_on <= 1'b1;
			repeat (400) @(posedge clk);
			hold_on <= 1'b0;
			hold_req <= 1'b0;
		end
	end

	// receiver: checks each word against the oldest prediction
	always @(posedge clk) begin
		logic signed [SW-1:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_out++;
				if (ducked_q.size() == 0) begin
					$error("out_sample: no word expected, actual %0d", out_sample);
					fails++;
				end else begin
					want = ducked_q.pop_front();
					if (out_sample !== want) begin
						$error("out_sample: expected %0d, actual %0d", want, out_sample);
						fails++;
					end
				end
			end
			if (stall > 0)
				stall--;
			else if (!quiet && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 14);
			out_ready <= !hold_on && !hold_req && (stall == 0);
		end
	end

	// register write, two-phase, setting the predictor at the write edge
	task automatic reg_write(input int idx, input longint val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 5'(idx * 4); pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_ATTACK:  att_c = val & 16'hFFFF;
			REG_RELEASE: rel_c = val & 16'hFFFF;
			REG_THRESH:  thr_c = longint'($signed(16'(val)));
			REG_SLOPE:   slope_c = val & 16'hFFFF;
			REG_MIX:     mix_c = val & 17'h1FFFF;
			default: ;
		endcase
	endtask

	task automatic push_word(input longint mn, input longint sd);
		word_t w;
		w.main_s = SW'(mn);
		w.side_s = SW'(sd);
		word_q.push_back(w);
		n_push++;
	endtask

	// every queued word has come back out
	task automatic wait_idle();
		wait (word_q.size() == 0 && n_out == n_push);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic longint rand_sample();
		longint v;
		v = longint'($signed(SW'($urandom())));
		case ($urandom_range(0, 3))
			0: return v;
			1: return v >>> $urandom_range(1, 22);
			2: return $urandom_range(0, 1) ? SMAX : -SMAX - 1;
			default: return v >>> 12;
		endcase
	endfunction

	initial begin
		longint cfg [5];
		make_tables();
		att_c = 65400; rel_c = 65509; thr_c = -7680; slope_c = 49152; mix_c = 65536;
		env_acc = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed words under reset settings
		push_word(0, 0);
		push_word(SMAX, 0);
		push_word(-SMAX - 1, 0);
		for (int i = 0; i < 6; i++) push_word(SMAX, -SMAX - 1);
		for (int i = 0; i < 4; i++) push_word(-SMAX - 1, SMAX);
		push_word(-1, 1);
		push_word(1, -1);
		for (int i = 0; i < 4; i++) push_word(4_000_000 - i, 0);
		push_word(-12345, 8388607);
		push_word(77, 0);
		wait_idle();

		for (int ph = 1; ph < NPHASE; ph++) begin
			case (ph)
				1: cfg = '{0, 0, -30720, 65535, 65536};
				2: cfg = '{65535, 65535, 0, 0, 0};
				3: cfg = '{100, 60000, 256, 65535, 131071};
				4: cfg = '{0, 65535, -32768, 65535, 65537};
				default: begin
					cfg[0] = $urandom_range(0, 65535);
					cfg[1] = $urandom_range(0, 65535);
					cfg[2] = longint'($signed(16'($urandom())));
					cfg[3] = $urandom_range(0, 65535);
					cfg[4] = $urandom_range(0, 131071);
				end
			endcase
			for (int i = 0; i < 5; i++) reg_write(i, cfg[i]);
			// unmapped addresses are ignored
			reg_write($urandom_range(5, 7), $urandom());
			if (ph == NPHASE - 1) quiet = 1'b1;
			if (ph == 2) hold_req = 1'b1;
			for (int i = 0; i < 15; i++) begin
				// loud key bursts followed by silence drive attack and release
				if ($urandom_range(0, 2) == 0) begin
					for (int k = $urandom_range(2, 8); k > 0; k--)
						push_word(rand_sample(), $urandom_range(0, 1) ? SMAX : -SMAX - 1);
					for (int k = $urandom_range(1, 6); k > 0; k--)
						push_word(rand_sample(), 0);
				end else
					push_word(rand_sample(), rand_sample());
			end
			wait_idle();
		end

		$display("Covered %0d words in %0d phases, %0d with gain reduction.",
			n_in, NPHASE, n_reduced);
		if (fails == 0 && ducked_q.size() == 0 && n_out == n_in)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sdc_pkg.sv
rtl/sdc_ctrl.sv
rtl/sdc_datapath.sv
rtl/sidechain_ducking_compressor_unit.sv
test/tb_sidechain_ducking_compressor_unit.sv
